### rtl/core/arl_pkg.sv
// shared types and codes for the anchored rectangle layout block
`timescale 1ns / 1ps
`default_nettype none

package arl_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_POSITION   = 3'd0,
      CSR_BASE_SIZE  = 3'd1,
      CSR_SCALE      = 3'd2,
      CSR_PIVOT      = 3'd3,
      CSR_ANCHOR_MIN = 3'd4,
      CSR_ANCHOR_MAX = 3'd5,
      CSR_LAYOUT     = 3'd6
   } arl_csr_type;

   // stretch modes held in layout_mode bits 1:0
   typedef enum logic [1:0] {
      STRETCH_NONE  = 2'd0,
      STRETCH_HORIZ = 2'd1,
      STRETCH_VERT  = 2'd2,
      STRETCH_BOTH  = 2'd3
   } arl_stretch_type;

   // keep-aspect flag position in layout_mode
   localparam int KEEP_BIT = 2;

   // per-beat control that travels with the data
   typedef struct packed {
      logic valid;
      logic flag;
      logic div_en;
      logic div_to_w;
      logic post_mul;
   } arl_ctl_type;

endpackage

`default_nettype wire

### rtl/core/arl_front.sv
// front pipeline: anchors, spans, scales, sizes and the aspect numerator
`timescale 1ns / 1ps
`default_nettype none

module arl_front #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic signed [CW-1:0]  parent_x,
   input  logic signed [CW-1:0]  parent_y,
   input  logic signed [CW-1:0]  parent_w,
   input  logic signed [CW-1:0]  parent_h,
   input  logic signed [CW-1:0]  iscale_x,
   input  logic signed [CW-1:0]  iscale_y,
   input  logic                  unanchored,
   input  logic signed [CW-1:0]  pos_x,
   input  logic signed [CW-1:0]  pos_y,
   input  logic signed [CW-1:0]  base_w,
   input  logic signed [CW-1:0]  base_h,
   input  logic signed [CW-1:0]  scale_x,
   input  logic signed [CW-1:0]  scale_y,
   input  logic signed [CW-1:0]  amin_x,
   input  logic signed [CW-1:0]  amin_y,
   input  logic signed [CW-1:0]  amax_x,
   input  logic signed [CW-1:0]  amax_y,
   input  arl_pkg::arl_stretch_type stretch,
   input  logic                  keep,
   output arl_pkg::arl_ctl_type  ctl,
   output logic signed [2*CW-1:0] num,
   output logic signed [CW-1:0]  den,
   output logic signed [CW-1:0]  w,
   output logic signed [CW-1:0]  h,
   output logic signed [CW-1:0]  ref_x,
   output logic signed [CW-1:0]  ref_y,
   output logic signed [CW-1:0]  es_x,
   output logic signed [CW-1:0]  es_y
);

   localparam int PW = 2 * CW;
   localparam int SW = 2 * CW + 2;
   localparam int ONE = 1 << FB;
   localparam logic signed [CW-1:0] CMAX_C = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] CMAX_S = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] CMIN_S = ~CMAX_S;

   function automatic logic ovf(input logic signed [SW-1:0] v);
      return (v > CMAX_S) || (v < CMIN_S);
   endfunction

   function automatic logic signed [CW-1:0] clip(input logic signed [SW-1:0] v);
      if (v > CMAX_S) return CMAX_C;
      if (v < CMIN_S) return ~CMAX_C;
      return v[CW-1:0];
   endfunction

   function automatic logic signed [PW-1:0] mul(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
      return PW'(a) * PW'(b);
   endfunction

   function automatic logic signed [CW-1:0] clamp01(input logic signed [CW-1:0] a);
      if (a < 0) return '0;
      if (a > ONE) return CW'(ONE);
      return a;
   endfunction

   // stage 1: all products that depend only on the beat and config
   logic                 v1_ff, un1_ff;
   logic signed [CW-1:0] px1_ff, py1_ff;
   logic signed [PW-1:0] pamnx1_ff, pamxx1_ff, pamny1_ff, pamxy1_ff;
   logic signed [PW-1:0] pesx1_ff, pesy1_ff, pspx1_ff, pspy1_ff, puw1_ff, puh1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         un1_ff    <= unanchored;
         px1_ff    <= parent_x;
         py1_ff    <= parent_y;
         pamnx1_ff <= mul(parent_w, clamp01(amin_x));
         pamxx1_ff <= mul(parent_w, clamp01(amax_x));
         pamny1_ff <= mul(parent_h, clamp01(amin_y));
         pamxy1_ff <= mul(parent_h, clamp01(amax_y));
         pesx1_ff  <= mul(scale_x, iscale_x);
         pesy1_ff  <= mul(scale_y, iscale_y);
         pspx1_ff  <= mul(pos_x, iscale_x);
         pspy1_ff  <= mul(pos_y, iscale_y);
         puw1_ff   <= mul(base_w, scale_x);
         puh1_ff   <= mul(base_h, scale_y);
      end
   end

   // stage 2: anchor edges, effective scale, scaled position
   logic                 v2_ff, un2_ff, flag2_ff, flag2_in;
   logic signed [CW-1:0] lox2_ff, hix2_ff, loy2_ff, hiy2_ff;
   logic signed [CW-1:0] esx2_ff, esy2_ff, spx2_ff, spy2_ff, uw2_ff, uh2_ff;
   logic signed [SW-1:0] s_lox, s_hix, s_loy, s_hiy, s_esx, s_esy, s_spx, s_spy, s_uw, s_uh;

   always_comb begin
      s_lox = SW'(px1_ff) + SW'(pamnx1_ff >>> FB);
      s_hix = SW'(px1_ff) + SW'(pamxx1_ff >>> FB);
      s_loy = SW'(py1_ff) + SW'(pamny1_ff >>> FB);
      s_hiy = SW'(py1_ff) + SW'(pamxy1_ff >>> FB);
      s_esx = SW'(pesx1_ff >>> FB);
      s_esy = SW'(pesy1_ff >>> FB);
      s_spx = SW'(pspx1_ff >>> FB);
      s_spy = SW'(pspy1_ff >>> FB);
      s_uw  = SW'(puw1_ff >>> FB);
      s_uh  = SW'(puh1_ff >>> FB);
      if (un1_ff) begin
         flag2_in = ovf(s_uw) | (!keep & ovf(s_uh));
      end else begin
         flag2_in = ovf(s_lox) | ovf(s_hix) | ovf(s_loy) | ovf(s_hiy) |
                    ovf(s_esx) | ovf(s_esy) | ovf(s_spx) | ovf(s_spy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         un2_ff   <= un1_ff;
         flag2_ff <= flag2_in;
         lox2_ff  <= clip(s_lox);
         hix2_ff  <= clip(s_hix);
         loy2_ff  <= clip(s_loy);
         hiy2_ff  <= clip(s_hiy);
         esx2_ff  <= clip(s_esx);
         esy2_ff  <= clip(s_esy);
         spx2_ff  <= clip(s_spx);
         spy2_ff  <= clip(s_spy);
         uw2_ff   <= clip(s_uw);
         uh2_ff   <= clip(s_uh);
      end
   end

   // stage 3: stretch spans and centers
   logic                 v3_ff, un3_ff, flag3_ff, flag3_in;
   logic signed [CW-1:0] spw3_ff, sph3_ff, cx3_ff, cy3_ff, spw3_in, sph3_in;
   logic signed [CW-1:0] lox3_ff, loy3_ff, esx3_ff, esy3_ff, spx3_ff, spy3_ff;
   logic signed [CW-1:0] uw3_ff, uh3_ff;
   logic signed [SW-1:0] s_spw, s_sph, s_cx, s_cy;

   always_comb begin
      s_spw   = SW'(hix2_ff) - SW'(lox2_ff);
      s_sph   = SW'(hiy2_ff) - SW'(loy2_ff);
      s_cx    = (SW'(lox2_ff) + SW'(hix2_ff)) >>> 1;
      s_cy    = (SW'(loy2_ff) + SW'(hiy2_ff)) >>> 1;
      spw3_in = clip(s_spw);
      sph3_in = clip(s_sph);
      if (spw3_in < 0) spw3_in = '0;
      if (sph3_in < 0) sph3_in = '0;
      flag3_in = flag2_ff | (!un2_ff & (ovf(s_spw) | ovf(s_sph)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         un3_ff   <= un2_ff;
         flag3_ff <= flag3_in;
         spw3_ff  <= spw3_in;
         sph3_ff  <= sph3_in;
         cx3_ff   <= s_cx[CW-1:0];
         cy3_ff   <= s_cy[CW-1:0];
         lox3_ff  <= lox2_ff;
         loy3_ff  <= loy2_ff;
         esx3_ff  <= esx2_ff;
         esy3_ff  <= esy2_ff;
         spx3_ff  <= spx2_ff;
         spy3_ff  <= spy2_ff;
         uw3_ff   <= uw2_ff;
         uh3_ff   <= uh2_ff;
      end
   end

   // stage 4: reference point and size products
   logic                 v4_ff, un4_ff, flag4_ff, flag4_in;
   logic signed [CW-1:0] refx4_ff, refy4_ff, refx4_in, refy4_in;
   logic signed [PW-1:0] pw4_ff, ph4_ff, pw4_in, ph4_in;
   logic signed [CW-1:0] spw4_ff, sph4_ff, esx4_ff, esy4_ff, uw4_ff, uh4_ff;
   logic signed [CW-1:0] basex, basey;
   logic signed [SW-1:0] s_rx, s_ry;

   always_comb begin
      basex = ((stretch == arl_pkg::STRETCH_HORIZ) || (stretch == arl_pkg::STRETCH_BOTH)) ?
              cx3_ff : lox3_ff;
      basey = ((stretch == arl_pkg::STRETCH_VERT) || (stretch == arl_pkg::STRETCH_BOTH)) ?
              cy3_ff : loy3_ff;
      s_rx = SW'(basex) + SW'(spx3_ff);
      s_ry = SW'(basey) + SW'(spy3_ff);
      refx4_in = un3_ff ? pos_x : clip(s_rx);
      refy4_in = un3_ff ? pos_y : clip(s_ry);
      flag4_in = flag3_ff | (!un3_ff & (ovf(s_rx) | ovf(s_ry)));
      if (stretch == arl_pkg::STRETCH_BOTH) begin
         pw4_in = mul(spw3_ff, scale_x);
         ph4_in = mul(sph3_ff, scale_y);
      end else begin
         pw4_in = mul(base_w, esx3_ff);
         ph4_in = mul(base_h, esy3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         un4_ff   <= un3_ff;
         flag4_ff <= flag4_in;
         refx4_ff <= refx4_in;
         refy4_ff <= refy4_in;
         pw4_ff   <= pw4_in;
         ph4_ff   <= ph4_in;
         spw4_ff  <= spw3_ff;
         sph4_ff  <= sph3_ff;
         esx4_ff  <= esx3_ff;
         esy4_ff  <= esy3_ff;
         uw4_ff   <= uw3_ff;
         uh4_ff   <= uh3_ff;
      end
   end

   // stage 5: first width and height, and which side the aspect division fills
   arl_pkg::arl_ctl_type ctl5_ff, ctl5_in;
   logic signed [CW-1:0] w5_ff, h5_ff, w5_in, h5_in;
   logic signed [CW-1:0] refx5_ff, refy5_ff, esx5_ff, esy5_ff;
   logic signed [SW-1:0] s_wp, s_hp;

   always_comb begin
      s_wp = SW'(pw4_ff >>> FB);
      s_hp = SW'(ph4_ff >>> FB);
      ctl5_in = '0;
      ctl5_in.valid = v4_ff;
      ctl5_in.flag  = flag4_ff;
      w5_in = clip(s_wp);
      h5_in = clip(s_hp);
      if (un4_ff) begin
         w5_in = uw4_ff;
         h5_in = uh4_ff;
         ctl5_in.div_en = keep;
      end else begin
         case (stretch)
            arl_pkg::STRETCH_BOTH: begin
               if (w5_in < 0) w5_in = '0;
               if (h5_in < 0) h5_in = '0;
               ctl5_in.flag = flag4_ff | ovf(s_wp) | ovf(s_hp);
            end
            arl_pkg::STRETCH_HORIZ: begin
               w5_in = spw4_ff;
               h5_in = spw4_ff;
               ctl5_in.div_en   = 1'b1;
               ctl5_in.post_mul = !keep;
            end
            arl_pkg::STRETCH_VERT: begin
               w5_in = sph4_ff;
               h5_in = sph4_ff;
               ctl5_in.div_en   = 1'b1;
               ctl5_in.div_to_w = 1'b1;
               ctl5_in.post_mul = !keep;
            end
            default: begin
               ctl5_in.flag   = flag4_ff | ovf(s_wp) | (!keep & ovf(s_hp));
               ctl5_in.div_en = keep;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
      end else if (advance) begin
         ctl5_ff <= ctl5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w5_ff    <= w5_in;
         h5_ff    <= h5_in;
         refx5_ff <= refx4_ff;
         refy5_ff <= refy4_ff;
         esx5_ff  <= esx4_ff;
         esy5_ff  <= esy4_ff;
      end
   end

   // stage 6: aspect numerator and divisor
   arl_pkg::arl_ctl_type ctl6_ff;
   logic signed [PW-1:0] num6_ff;
   logic signed [CW-1:0] den6_ff, w6_ff, h6_ff, refx6_ff, refy6_ff, esx6_ff, esy6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl6_ff <= '0;
      end else if (advance) begin
         ctl6_ff <= ctl5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num6_ff  <= ctl5_ff.div_to_w ? mul(h5_ff, base_w) : mul(w5_ff, base_h);
         den6_ff  <= ctl5_ff.div_to_w ? base_h : base_w;
         w6_ff    <= w5_ff;
         h6_ff    <= h5_ff;
         refx6_ff <= refx5_ff;
         refy6_ff <= refy5_ff;
         esx6_ff  <= esx5_ff;
         esy6_ff  <= esy5_ff;
      end
   end

   assign ctl   = ctl6_ff;
   assign num   = num6_ff;
   assign den   = den6_ff;
   assign w     = w6_ff;
   assign h     = h6_ff;
   assign ref_x = refx6_ff;
   assign ref_y = refy6_ff;
   assign es_x  = esx6_ff;
   assign es_y  = esy6_ff;

endmodule

`default_nettype wire

### rtl/core/arl_div.sv
// pipelined restoring divider, one quotient bit per stage, carries beat data along
`timescale 1ns / 1ps
`default_nettype none

module arl_div #(
   parameter int CW     = 32,
   parameter int DATA_W = 192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  arl_pkg::arl_ctl_type   in_ctl,
   input  logic signed [2*CW-1:0] in_num,
   input  logic signed [CW-1:0]   in_den,
   input  logic [DATA_W-1:0]      in_data,
   output arl_pkg::arl_ctl_type   out_ctl,
   output logic [2*CW-2:0]        out_qmag,
   output logic                   out_neg,
   output logic [DATA_W-1:0]      out_data
);

   localparam int NW = 2 * CW - 1;

   arl_pkg::arl_ctl_type ctl_ff  [0:NW];
   logic [CW-1:0]        rem_ff  [0:NW];
   logic [NW-1:0]        quo_ff  [0:NW];
   logic [CW-1:0]        dmag_ff [0:NW];
   logic                 neg_ff  [0:NW];
   logic [DATA_W-1:0]    data_ff [0:NW];

   // stage 0: magnitudes and quotient sign
   logic signed [2*CW-1:0] num_neg;
   logic signed [CW-1:0]   den_neg;
   logic [NW-1:0]          nmag_in;
   logic [CW-1:0]          dmag_in;

   always_comb begin
      num_neg = -in_num;
      den_neg = -in_den;
      nmag_in = in_num[2*CW-1] ? num_neg[NW-1:0] : in_num[NW-1:0];
      dmag_in = in_den[CW-1] ? den_neg : in_den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (advance) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= '0;
         quo_ff[0]  <= nmag_in;
         dmag_ff[0] <= dmag_in;
         neg_ff[0]  <= in_num[2*CW-1] ^ in_den[CW-1];
         data_ff[0] <= in_data;
      end
   end

   // one shift-subtract step per stage
   for (genvar k = 1; k <= NW; k++) begin : g_step
      logic [CW:0]   trial;
      logic [CW:0]   diff;
      logic          ge;
      logic [CW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k-1], quo_ff[k-1][NW-1]};
         diff   = trial - {1'b0, dmag_ff[k-1]};
         ge     = trial >= {1'b0, dmag_ff[k-1]};
         rem_in = ge ? diff[CW-1:0] : trial[CW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (advance) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= {quo_ff[k-1][NW-2:0], ge};
            dmag_ff[k] <= dmag_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign out_ctl  = ctl_ff[NW];
   assign out_qmag = quo_ff[NW];
   assign out_neg  = neg_ff[NW];
   assign out_data = data_ff[NW];

endmodule

`default_nettype wire

### rtl/core/arl_back.sv
// back pipeline: aspect result, stretch rescale, pivot offset and final edges
`timescale 1ns / 1ps
`default_nettype none

module arl_back #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  arl_pkg::arl_ctl_type  in_ctl,
   input  logic [2*CW-2:0]       in_qmag,
   input  logic                  in_neg,
   input  logic signed [CW-1:0]  in_w,
   input  logic signed [CW-1:0]  in_h,
   input  logic signed [CW-1:0]  in_ref_x,
   input  logic signed [CW-1:0]  in_ref_y,
   input  logic signed [CW-1:0]  in_es_x,
   input  logic signed [CW-1:0]  in_es_y,
   input  logic signed [CW-1:0]  base_w,
   input  logic signed [CW-1:0]  base_h,
   input  logic signed [CW-1:0]  pivot_x,
   input  logic signed [CW-1:0]  pivot_y,
   output logic                  out_valid,
   output logic signed [CW-1:0]  out_x,
   output logic signed [CW-1:0]  out_y,
   output logic signed [CW-1:0]  out_w,
   output logic signed [CW-1:0]  out_h,
   output logic                  out_flag
);

   localparam int PW = 2 * CW;
   localparam int SW = 2 * CW + 2;
   localparam logic signed [CW-1:0] CMAX_C = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] CMAX_S = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] CMIN_S = ~CMAX_S;

   function automatic logic ovf(input logic signed [SW-1:0] v);
      return (v > CMAX_S) || (v < CMIN_S);
   endfunction

   function automatic logic signed [CW-1:0] clip(input logic signed [SW-1:0] v);
      if (v > CMAX_S) return CMAX_C;
      if (v < CMIN_S) return ~CMAX_C;
      return v[CW-1:0];
   endfunction

   function automatic logic signed [PW-1:0] mul(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
      return PW'(a) * PW'(b);
   endfunction

   // stage 1: signed quotient, special divisor cases
   arl_pkg::arl_ctl_type ctl1_ff, ctl1_in;
   logic signed [CW-1:0] w1_ff, h1_ff, w1_in, h1_in, res, src;
   logic signed [CW-1:0] rx1_ff, ry1_ff, esx1_ff, esy1_ff;
   logic signed [SW-1:0] q_abs, q_s;
   logic                 res_flag;

   always_comb begin
      q_abs = $signed(SW'(in_qmag));
      q_s   = in_neg ? -q_abs : q_abs;
      src   = in_ctl.div_to_w ? in_h : in_w;
      if (base_h <= 0) begin
         res      = src;
         res_flag = 1'b0;
      end else if (!in_ctl.div_to_w && (base_w == 0)) begin
         // zero base width: saturate toward the sign of the width
         res      = (in_w > 0) ? CMAX_C : ((in_w < 0) ? ~CMAX_C : '0);
         res_flag = 1'b1;
      end else begin
         res      = clip(q_s);
         res_flag = ovf(q_s);
      end
      ctl1_in = in_ctl;
      w1_in   = in_w;
      h1_in   = in_h;
      if (in_ctl.div_en) begin
         ctl1_in.flag = in_ctl.flag | res_flag;
         if (in_ctl.div_to_w) begin
            w1_in = res;
         end else begin
            h1_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= ctl1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w1_ff   <= w1_in;
         h1_ff   <= h1_in;
         rx1_ff  <= in_ref_x;
         ry1_ff  <= in_ref_y;
         esx1_ff <= in_es_x;
         esy1_ff <= in_es_y;
      end
   end

   // stage 2: rescale of the derived side
   arl_pkg::arl_ctl_type ctl2_ff;
   logic signed [PW-1:0] pp2_ff;
   logic signed [CW-1:0] w2_ff, h2_ff, rx2_ff, ry2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else if (advance) begin
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp2_ff <= ctl1_ff.div_to_w ? mul(w1_ff, esx1_ff) : mul(h1_ff, esy1_ff);
         w2_ff  <= w1_ff;
         h2_ff  <= h1_ff;
         rx2_ff <= rx1_ff;
         ry2_ff <= ry1_ff;
      end
   end

   // stage 3: saturate the rescaled side
   arl_pkg::arl_ctl_type ctl3_ff, ctl3_in;
   logic signed [CW-1:0] w3_ff, h3_ff, w3_in, h3_in, rx3_ff, ry3_ff;
   logic signed [SW-1:0] s_pp;

   always_comb begin
      s_pp    = SW'(pp2_ff >>> FB);
      ctl3_in = ctl2_ff;
      w3_in   = w2_ff;
      h3_in   = h2_ff;
      if (ctl2_ff.post_mul) begin
         ctl3_in.flag = ctl2_ff.flag | ovf(s_pp);
         if (ctl2_ff.div_to_w) begin
            w3_in = clip(s_pp);
         end else begin
            h3_in = clip(s_pp);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else if (advance) begin
         ctl3_ff <= ctl3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w3_ff  <= w3_in;
         h3_ff  <= h3_in;
         rx3_ff <= rx2_ff;
         ry3_ff <= ry2_ff;
      end
   end

   // stage 4: pivot products
   arl_pkg::arl_ctl_type ctl4_ff;
   logic signed [PW-1:0] pvx4_ff, pvy4_ff;
   logic signed [CW-1:0] w4_ff, h4_ff, rx4_ff, ry4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else if (advance) begin
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pvx4_ff <= mul(pivot_x, w3_ff);
         pvy4_ff <= mul(pivot_y, h3_ff);
         w4_ff   <= w3_ff;
         h4_ff   <= h3_ff;
         rx4_ff  <= rx3_ff;
         ry4_ff  <= ry3_ff;
      end
   end

   // stage 5: final edges
   logic                 v5_ff, flag5_ff;
   logic signed [CW-1:0] x5_ff, y5_ff, w5_ff, h5_ff;
   logic signed [SW-1:0] s_x, s_y;

   always_comb begin
      s_x = SW'(rx4_ff) - SW'(pvx4_ff >>> FB);
      s_y = SW'(ry4_ff) - SW'(pvy4_ff >>> FB);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= ctl4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flag5_ff <= ctl4_ff.flag | ovf(s_x) | ovf(s_y);
         x5_ff    <= clip(s_x);
         y5_ff    <= clip(s_y);
         w5_ff    <= w4_ff;
         h5_ff    <= h4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_x     = x5_ff;
   assign out_y     = y5_ff;
   assign out_w     = w5_ff;
   assign out_h     = h5_ff;
   assign out_flag  = flag5_ff;

endmodule

`default_nettype wire

### rtl/core/arl_out_buf.sv
// two-entry result buffer between the pipeline and the result channel
`timescale 1ns / 1ps
`default_nettype none

module arl_out_buf #(
   parameter int W = 129
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         out_ready,
   output logic         out_valid,
   output logic [W-1:0] out_data,
   output logic         full
);

   logic [W-1:0] entry_ff [0:1];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign out_valid = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign pop       = out_valid & out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   // occupancy follows push and pop
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (!push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

### rtl/core/anchored_rect_layout_top.sv
// top level of the anchored rectangle layout block
`timescale 1ns / 1ps
`default_nettype none

// Places a child rectangle inside a parent rectangle from the configured
// position, base size, scale, pivot, anchors and layout mode, all signed fixed
// point with FRAC_BITS fraction bits. One parent rectangle is accepted every
// cycle while the result buffer has room and gives one result rectangle;
// results come out in order. The aspect divider resolves one quotient bit per
// pipeline stage over the full product width. A two-entry result buffer lets
// the block keep taking beats while a result waits; req_ready drops only when
// both entries are full. Every clamp to the coordinate range and a division by
// a zero base width raise rsp_saturated. Configuration writes take effect at
// once and are meant for times when nothing is in flight.
module anchored_rect_layout_top #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_parent_x,
   input  logic [31:0] req_parent_y,
   input  logic [31:0] req_parent_w,
   input  logic [31:0] req_parent_h,
   input  logic [31:0] req_inherited_scale_x,
   input  logic [31:0] req_inherited_scale_y,
   input  logic        req_unanchored,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_rect_x,
   output logic [31:0] rsp_rect_y,
   output logic [31:0] rsp_rect_w,
   output logic [31:0] rsp_rect_h,
   output logic        rsp_saturated,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int DATA_W = 6 * CW;
   localparam int OUT_W  = 4 * CW + 1;
   localparam logic [CW-1:0] ONE_C = CW'(1 << FRAC_BITS);

   // configuration registers, one half per axis
   logic signed [CW-1:0] pos_x_ff, pos_y_ff, base_w_ff, base_h_ff;
   logic signed [CW-1:0] scale_x_ff, scale_y_ff, pivot_x_ff, pivot_y_ff;
   logic signed [CW-1:0] amin_x_ff, amin_y_ff, amax_x_ff, amax_y_ff;
   arl_pkg::arl_stretch_type stretch_ff;
   logic keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         base_w_ff  <= '0;
         base_h_ff  <= '0;
         scale_x_ff <= ONE_C;
         scale_y_ff <= ONE_C;
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
         amin_x_ff  <= '0;
         amin_y_ff  <= '0;
         amax_x_ff  <= '0;
         amax_y_ff  <= '0;
         stretch_ff <= arl_pkg::STRETCH_NONE;
         keep_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            arl_pkg::CSR_POSITION: begin
               pos_x_ff <= csr_wdata[CW-1:0];
               pos_y_ff <= csr_wdata[32+CW-1:32];
            end
            arl_pkg::CSR_BASE_SIZE: begin
               base_w_ff <= csr_wdata[CW-1:0];
               base_h_ff <= csr_wdata[32+CW-1:32];
            end
            arl_pkg::CSR_SCALE: begin
               scale_x_ff <= csr_wdata[CW-1:0];
               scale_y_ff <= csr_wdata[32+CW-1:32];
            end
            arl_pkg::CSR_PIVOT: begin
               pivot_x_ff <= csr_wdata[CW-1:0];
               pivot_y_ff <= csr_wdata[32+CW-1:32];
            end
            arl_pkg::CSR_ANCHOR_MIN: begin
               amin_x_ff <= csr_wdata[CW-1:0];
               amin_y_ff <= csr_wdata[32+CW-1:32];
            end
            arl_pkg::CSR_ANCHOR_MAX: begin
               amax_x_ff <= csr_wdata[CW-1:0];
               amax_y_ff <= csr_wdata[32+CW-1:32];
            end
            arl_pkg::CSR_LAYOUT: begin
               stretch_ff <= arl_pkg::arl_stretch_type'(csr_wdata[1:0]);
               keep_ff    <= csr_wdata[arl_pkg::KEEP_BIT];
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline moves whenever the result buffer has room
   logic buf_full, advance;
   assign advance   = ~buf_full;
   assign req_ready = advance;

   arl_pkg::arl_ctl_type   f_ctl, d_ctl;
   logic signed [2*CW-1:0] f_num;
   logic signed [CW-1:0]   f_den, f_w, f_h, f_rx, f_ry, f_esx, f_esy;
   logic [DATA_W-1:0]      d_data;
   logic [2*CW-2:0]        d_qmag;
   logic                   d_neg;

   arl_front #(.CW(CW), .FB(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .parent_x   (req_parent_x[CW-1:0]),
      .parent_y   (req_parent_y[CW-1:0]),
      .parent_w   (req_parent_w[CW-1:0]),
      .parent_h   (req_parent_h[CW-1:0]),
      .iscale_x   (req_inherited_scale_x[CW-1:0]),
      .iscale_y   (req_inherited_scale_y[CW-1:0]),
      .unanchored (req_unanchored),
      .pos_x      (pos_x_ff),
      .pos_y      (pos_y_ff),
      .base_w     (base_w_ff),
      .base_h     (base_h_ff),
      .scale_x    (scale_x_ff),
      .scale_y    (scale_y_ff),
      .amin_x     (amin_x_ff),
      .amin_y     (amin_y_ff),
      .amax_x     (amax_x_ff),
      .amax_y     (amax_y_ff),
      .stretch    (stretch_ff),
      .keep       (keep_ff),
      .ctl        (f_ctl),
      .num        (f_num),
      .den        (f_den),
      .w          (f_w),
      .h          (f_h),
      .ref_x      (f_rx),
      .ref_y      (f_ry),
      .es_x       (f_esx),
      .es_y       (f_esy)
   );

   arl_div #(.CW(CW), .DATA_W(DATA_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (f_ctl),
      .in_num   (f_num),
      .in_den   (f_den),
      .in_data  ({f_esy, f_esx, f_ry, f_rx, f_h, f_w}),
      .out_ctl  (d_ctl),
      .out_qmag (d_qmag),
      .out_neg  (d_neg),
      .out_data (d_data)
   );

   logic                 b_valid, b_flag;
   logic signed [CW-1:0] b_x, b_y, b_w, b_h;

   arl_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (d_ctl),
      .in_qmag   (d_qmag),
      .in_neg    (d_neg),
      .in_w      (d_data[CW-1:0]),
      .in_h      (d_data[2*CW-1:CW]),
      .in_ref_x  (d_data[3*CW-1:2*CW]),
      .in_ref_y  (d_data[4*CW-1:3*CW]),
      .in_es_x   (d_data[5*CW-1:4*CW]),
      .in_es_y   (d_data[6*CW-1:5*CW]),
      .base_w    (base_w_ff),
      .base_h    (base_h_ff),
      .pivot_x   (pivot_x_ff),
      .pivot_y   (pivot_y_ff),
      .out_valid (b_valid),
      .out_x     (b_x),
      .out_y     (b_y),
      .out_w     (b_w),
      .out_h     (b_h),
      .out_flag  (b_flag)
   );

   logic [OUT_W-1:0] buf_data;

   arl_out_buf #(.W(OUT_W)) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance & b_valid),
      .push_data ({b_flag, b_h, b_w, b_y, b_x}),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (buf_data),
      .full      (buf_full)
   );

   // sign-extend results to the port width
   assign rsp_rect_x    = 32'($signed(buf_data[CW-1:0]));
   assign rsp_rect_y    = 32'($signed(buf_data[2*CW-1:CW]));
   assign rsp_rect_w    = 32'($signed(buf_data[3*CW-1:2*CW]));
   assign rsp_rect_h    = 32'($signed(buf_data[4*CW-1:3*CW]));
   assign rsp_saturated = buf_data[4*CW];

endmodule

`default_nettype wire

### rtl/core/arl_checker.sv
// port-level checks for the anchored rectangle layout block, bound to the top
`timescale 1ns / 1ps
`default_nettype none

module arl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_rect_x,
   input logic [31:0] rsp_rect_y,
   input logic [31:0] rsp_rect_w,
   input logic [31:0] rsp_rect_h,
   input logic        rsp_saturated
);

   // no result is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rect_x) &&
      $stable(rsp_rect_y) && $stable(rsp_rect_w) && $stable(rsp_rect_h) &&
      $stable(rsp_saturated))
      else $error("stalled result beat changed");

   // with no result waiting the block must take input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result buffer");

   // a full buffer that is not drained stays full
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready && !rsp_ready |=> !req_ready && rsp_valid)
      else $error("full result buffer drained without a beat");

endmodule

bind anchored_rect_layout_top arl_checker u_arl_checker (.*);

`default_nettype wire
